// ===== sv/sen_pkg.sv =====
// ----------------------------------------------------------------------------
// sen_pkg
// shared types and constants for the sobel edge / nms stream unit
// ----------------------------------------------------------------------------
`default_nettype none

package sen_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // position and frame size fields, wide enough for the largest frame plus flush rows
  localparam int POS_W  = 13;
  localparam int SIZE_W = 13;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MAG_W      = 9;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd481;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd321;

  localparam logic [7:0] EDGE_ON  = 8'd0;
  localparam logic [7:0] EDGE_OFF = 8'd255;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       drain;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]       edge_pixel;
    logic [MAG_W-1:0] magnitude;
    logic             last;
  } pixel_out_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic [7:0]        sample;
    logic              has_gray;
    logic              last;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [SIZE_W-1:0] fw;
    logic [SIZE_W-1:0] fh;
  } fe_entry_t;

endpackage

`default_nettype wire

// ===== sv/sen_fifo.sv =====
// ----------------------------------------------------------------------------
// sen_fifo
// short queue of classified transactions between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sen_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sen_pkg::fe_entry_t din,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output sen_pkg::fe_entry_t     dout
);
  import sen_pkg::*;

  fe_entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/sen_front.sv =====
// ----------------------------------------------------------------------------
// sen_front
// accepts pixels, tracks frame position, picks the bayer sample
// ----------------------------------------------------------------------------
`default_nettype none

module sen_front #(
  parameter int MAX_WIDTH  = sen_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sen_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire sen_pkg::pixel_in_t              in_data,
  input  wire logic [sen_pkg::CFG_DATA_W-1:0]  cfg_width,
  input  wire logic [sen_pkg::CFG_DATA_W-1:0]  cfg_height,
  output logic                                 push,
  output sen_pkg::fe_entry_t                   push_entry,
  input  wire logic                            q_full
);
  import sen_pkg::*;

  logic [POS_W-1:0]  row_r, col_r;
  logic [SIZE_W-1:0] fw_r, fh_r;
  logic [SIZE_W-1:0] fw_cur, fh_cur;
  logic              accept, start, ignore, finished;
  logic [7:0]        sample;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] ext;
    ext = SIZE_W'(v);
    if (ext < SIZE_W'(3)) begin
      return SIZE_W'(3);
    end else if (ext > hi) begin
      return hi;
    end
    return ext;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign start    = (row_r == '0) && (col_r == '0);
  assign fw_cur   = start ? clamp_size(cfg_width, SIZE_W'(MAX_WIDTH)) : fw_r;
  assign fh_cur   = start ? clamp_size(cfg_height, SIZE_W'(MAX_HEIGHT)) : fh_r;
  // early drain inside the frame is dropped
  assign ignore   = (row_r < fh_cur) && in_data.drain;
  assign push     = accept && !ignore;
  // last result leaves two rows and one pixel past the frame end
  assign finished = (row_r == fh_cur + SIZE_W'(2)) && (col_r == POS_W'(1));

  always_comb begin
    if (!row_r[0]) begin
      sample = col_r[0] ? in_data.green : in_data.red;
    end else begin
      sample = col_r[0] ? in_data.blue : in_data.green;
    end
  end

  always_comb begin
    push_entry.sample   = sample;
    push_entry.has_gray = (row_r < fh_cur);
    push_entry.last     = finished;
    push_entry.row      = row_r;
    push_entry.col      = col_r;
    push_entry.fw       = fw_cur;
    push_entry.fh       = fh_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      fw_r  <= SIZE_W'(3);
      fh_r  <= SIZE_W'(3);
    end else begin
      if (accept && start) begin
        fw_r <= fw_cur;
        fh_r <= fh_cur;
      end
      if (push) begin
        if (finished) begin
          row_r <= '0;
          col_r <= '0;
        end else if (col_r + POS_W'(1) >= fw_cur) begin
          col_r <= '0;
          row_r <= row_r + POS_W'(1);
        end else begin
          col_r <= col_r + POS_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sen_back.sv =====
// ----------------------------------------------------------------------------
// sen_back
// line buffers, sobel window walk, bit-serial root, suppression and output
// ----------------------------------------------------------------------------
`default_nettype none

module sen_back #(
  parameter int MAX_WIDTH = sen_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       ent_valid,
  input  wire sen_pkg::fe_entry_t         ent,
  output logic                            ent_pop,
  input  wire logic [sen_pkg::MAG_W-1:0]  mag_threshold,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output sen_pkg::pixel_out_t             out_data
);
  import sen_pkg::*;

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int AW        = CW + 2;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int MW_W      = MAG_W + 18;

  localparam logic [1:0] OFF_M1 = 2'd0;
  localparam logic [1:0] OFF_Z  = 2'd1;
  localparam logic [1:0] OFF_P1 = 2'd2;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_GWR  = 14'b00000000000010,
    S_GRD  = 14'b00000000000100,
    S_DIV  = 14'b00000000001000,
    S_SQX  = 14'b00000000010000,
    S_SQY  = 14'b00000000100000,
    S_SQRT = 14'b00000001000000,
    S_MWR  = 14'b00000010000000,
    S_CRD  = 14'b00000100000000,
    S_CCAP = 14'b00001000000000,
    S_N1   = 14'b00010000000000,
    S_N2   = 14'b00100000000000,
    S_CMP  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [7:0]      gray_mem [MEM_DEPTH];
  logic [MW_W-1:0] mag_mem  [MEM_DEPTH];
  logic [7:0]      gray_rdata_r;
  logic [MW_W-1:0] mag_rdata_r;
  logic [AW-1:0]   gray_raddr, mag_raddr;

  fe_entry_t          e_r;
  logic [POS_W-1:0]   rm_r, cm_r, rp_r, cp_r;
  logic [POS_W-1:0]   rm_d, cm_d, rp_d, cp_d;
  logic               do_mag_r, do_out_r, do_mag_d, do_out_d;
  logic [3:0]         kcnt_r;
  logic [1:0]         dr_code, dc_code, dr_prev_r, dc_prev_r;
  logic [POS_W-1:0]   row_sel, col_sel;
  logic signed [11:0] gx_acc_r, gy_acc_r, gx_term, gy_term;
  logic [9:0]         pix_x, pix_y;
  logic signed [8:0]  gx_r, gy_r;
  logic [7:0]         ax_r, ay_r;
  logic [16:0]        sum_r;
  logic [MAG_W-1:0]   root_r, trial, mag_th;
  logic [17:0]        trial_sq;
  logic [3:0]         bit_r;
  logic [MAG_W-1:0]   res_r, n1_r;
  logic [AW-1:0]      n1_addr_r, n2_addr_r, n1_addr_d, n2_addr_d;
  logic               pass_d;

  logic signed [8:0]  c_gx, c_gy;
  logic [7:0]         c_a, c_b;
  logic               cls_lo, cls_hi, same_sign;
  logic [POS_W-1:0]   rp_m1, rp_p1, cp_m1, cp_p1;
  logic               out_load;

  function automatic logic signed [11:0] trunc4(input logic signed [11:0] x);
    logic signed [11:0] nx;
    nx = -x;
    if (x < 0) begin
      return -(nx >>> 2);
    end
    return x >>> 2;
  endfunction

  // transaction position decode: mag center lags one row plus one, output two rows plus two
  always_comb begin
    if (ent.col == '0) begin
      rm_d = ent.row - POS_W'(2);
      cm_d = ent.fw - SIZE_W'(1);
    end else begin
      rm_d = ent.row - POS_W'(1);
      cm_d = ent.col - POS_W'(1);
    end
    if (ent.col >= POS_W'(2)) begin
      rp_d = ent.row - POS_W'(2);
      cp_d = ent.col - POS_W'(2);
    end else begin
      rp_d = ent.row - POS_W'(3);
      cp_d = ent.col + ent.fw - POS_W'(2);
    end
    do_mag_d = ((ent.row >= POS_W'(2)) || ((ent.row == POS_W'(1)) && (ent.col != '0)))
               && (rm_d < ent.fh);
    do_out_d = (ent.row >= POS_W'(3)) || ((ent.row == POS_W'(2)) && (ent.col >= POS_W'(2)));
  end

  // 3x3 window walk with reflected borders
  always_comb begin
    unique case (kcnt_r)
      4'd0:    begin dr_code = OFF_M1; dc_code = OFF_M1; end
      4'd1:    begin dr_code = OFF_M1; dc_code = OFF_Z;  end
      4'd2:    begin dr_code = OFF_M1; dc_code = OFF_P1; end
      4'd3:    begin dr_code = OFF_Z;  dc_code = OFF_M1; end
      4'd4:    begin dr_code = OFF_Z;  dc_code = OFF_Z;  end
      4'd5:    begin dr_code = OFF_Z;  dc_code = OFF_P1; end
      4'd6:    begin dr_code = OFF_P1; dc_code = OFF_M1; end
      4'd7:    begin dr_code = OFF_P1; dc_code = OFF_Z;  end
      4'd8:    begin dr_code = OFF_P1; dc_code = OFF_P1; end
      default: begin dr_code = OFF_Z;  dc_code = OFF_Z;  end
    endcase
  end

  always_comb begin
    unique case (dr_code)
      OFF_M1:  row_sel = (rm_r == '0) ? POS_W'(1) : rm_r - POS_W'(1);
      OFF_P1:  row_sel = (rm_r + POS_W'(1) == e_r.fh) ? e_r.fh - SIZE_W'(2)
                                                       : rm_r + POS_W'(1);
      default: row_sel = rm_r;
    endcase
    unique case (dc_code)
      OFF_M1:  col_sel = (cm_r == '0) ? POS_W'(1) : cm_r - POS_W'(1);
      OFF_P1:  col_sel = (cm_r + POS_W'(1) == e_r.fw) ? e_r.fw - SIZE_W'(2)
                                                       : cm_r + POS_W'(1);
      default: col_sel = cm_r;
    endcase
  end

  assign gray_raddr = {row_sel[1:0], col_sel[CW-1:0]};

  // 1-2-1 weights: center row/column doubles
  always_comb begin
    pix_x = (dr_prev_r == OFF_Z) ? {1'b0, gray_rdata_r, 1'b0} : {2'b00, gray_rdata_r};
    pix_y = (dc_prev_r == OFF_Z) ? {1'b0, gray_rdata_r, 1'b0} : {2'b00, gray_rdata_r};
    unique case (dc_prev_r)
      OFF_M1:  gx_term = -$signed({2'b00, pix_x});
      OFF_P1:  gx_term = $signed({2'b00, pix_x});
      default: gx_term = '0;
    endcase
    unique case (dr_prev_r)
      OFF_M1:  gy_term = $signed({2'b00, pix_y});
      OFF_P1:  gy_term = -$signed({2'b00, pix_y});
      default: gy_term = '0;
    endcase
  end

  assign trial    = root_r | (MAG_W'(1) << bit_r);
  assign trial_sq = trial * trial;
  assign mag_th   = (root_r <= mag_threshold) ? '0 : root_r;

  // direction class from the stored gradient pair
  always_comb begin
    c_gx      = $signed(mag_rdata_r[17:9]);
    c_gy      = $signed(mag_rdata_r[8:0]);
    c_a       = c_gx[8] ? 8'(-c_gx) : c_gx[7:0];
    c_b       = c_gy[8] ? 8'(-c_gy) : c_gy[7:0];
    cls_lo    = (c_gx != '0) && ({c_b, 16'h0000} < 24'(24'd27146 * c_a));
    cls_hi    = (c_gx != '0) && ({3'b000, c_b, 16'h0000} < 27'(27'd295614 * c_a));
    same_sign = ((c_gx > 0) == (c_gy > 0));
    rp_m1     = rp_r - POS_W'(1);
    rp_p1     = rp_r + POS_W'(1);
    cp_m1     = cp_r - POS_W'(1);
    cp_p1     = cp_r + POS_W'(1);
    pass_d    = (rp_r == '0) || (cp_r == '0) || (rp_r == e_r.fh - SIZE_W'(1)) ||
                (cp_r == e_r.fw - SIZE_W'(1)) || ((c_gx == '0) && (c_gy == '0));
    priority if (cls_lo) begin
      n1_addr_d = {rp_m1[1:0], cp_r[CW-1:0]};
      n2_addr_d = {rp_p1[1:0], cp_r[CW-1:0]};
    end else if (cls_hi && same_sign) begin
      n1_addr_d = {rp_m1[1:0], cp_m1[CW-1:0]};
      n2_addr_d = {rp_p1[1:0], cp_p1[CW-1:0]};
    end else if (cls_hi) begin
      n1_addr_d = {rp_m1[1:0], cp_p1[CW-1:0]};
      n2_addr_d = {rp_p1[1:0], cp_m1[CW-1:0]};
    end else begin
      n1_addr_d = {rp_r[1:0], cp_m1[CW-1:0]};
      n2_addr_d = {rp_r[1:0], cp_p1[CW-1:0]};
    end
  end

  always_comb begin
    unique case (state_r)
      S_N1:    mag_raddr = n1_addr_r;
      S_N2:    mag_raddr = n2_addr_r;
      default: mag_raddr = {rp_r[1:0], cp_r[CW-1:0]};
    endcase
  end

  assign ent_pop  = (state_r == S_IDLE) && ent_valid;
  assign out_load = (state_r == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (ent_valid) state_nxt = S_GWR;
      S_GWR: begin
        if (do_mag_r) begin
          state_nxt = S_GRD;
        end else if (do_out_r) begin
          state_nxt = S_CRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_GRD:   if (kcnt_r == 4'd9) state_nxt = S_DIV;
      S_DIV:   state_nxt = S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_SQRT;
      S_SQRT:  if (bit_r == '0) state_nxt = S_MWR;
      S_MWR:   state_nxt = do_out_r ? S_CRD : S_IDLE;
      S_CRD:   state_nxt = S_CCAP;
      S_CCAP:  state_nxt = pass_d ? S_OUT : S_N1;
      S_N1:    state_nxt = S_N2;
      S_N2:    state_nxt = S_CMP;
      S_CMP:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // line buffers
  always_ff @(posedge clk) begin
    if ((state_r == S_GWR) && e_r.has_gray) begin
      gray_mem[{e_r.row[1:0], e_r.col[CW-1:0]}] <= e_r.sample;
    end
    gray_rdata_r <= gray_mem[gray_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MWR) begin
      mag_mem[{rm_r[1:0], cm_r[CW-1:0]}] <= {mag_th, gx_r, gy_r};
    end
    mag_rdata_r <= mag_mem[mag_raddr];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        e_r      <= ent;
        rm_r     <= rm_d;
        cm_r     <= cm_d;
        rp_r     <= rp_d;
        cp_r     <= cp_d;
        do_mag_r <= do_mag_d;
        do_out_r <= do_out_d;
      end
      S_GWR: begin
        kcnt_r   <= '0;
        gx_acc_r <= '0;
        gy_acc_r <= '0;
      end
      S_GRD: begin
        if (kcnt_r != '0) begin
          gx_acc_r <= gx_acc_r + gx_term;
          gy_acc_r <= gy_acc_r + gy_term;
        end
        dr_prev_r <= dr_code;
        dc_prev_r <= dc_code;
        kcnt_r    <= kcnt_r + 4'd1;
      end
      S_DIV: begin
        gx_r <= 9'(trunc4(gx_acc_r));
        gy_r <= 9'(trunc4(gy_acc_r));
        ax_r <= 8'(gx_acc_r[11] ? -trunc4(gx_acc_r) : trunc4(gx_acc_r));
        ay_r <= 8'(gy_acc_r[11] ? -trunc4(gy_acc_r) : trunc4(gy_acc_r));
      end
      S_SQX:  sum_r <= 17'(ax_r * ax_r);
      S_SQY: begin
        sum_r  <= sum_r + 17'(ay_r * ay_r);
        root_r <= '0;
        bit_r  <= 4'(MAG_W - 1);
      end
      S_SQRT: begin
        if (trial_sq <= {1'b0, sum_r}) begin
          root_r <= trial;
        end
        bit_r <= bit_r - 4'd1;
      end
      S_CCAP: begin
        res_r     <= mag_rdata_r[MW_W-1:18];
        n1_addr_r <= n1_addr_d;
        n2_addr_r <= n2_addr_d;
      end
      S_N2:   n1_r <= mag_rdata_r[MW_W-1:18];
      S_CMP: begin
        if ((res_r < n1_r) || (res_r < mag_rdata_r[MW_W-1:18])) begin
          res_r <= '0;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_data.edge_pixel <= (res_r != '0) ? EDGE_ON : EDGE_OFF;
          out_data.magnitude  <= res_r;
          out_data.last       <= e_r.last;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRD) |-> (kcnt_r <= 4'd9))
    else $error("window walk overran");
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR) |-> (root_r <= MAG_W'(361)))
    else $error("root out of range");
  a_out_needs_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRD || state_r == S_OUT) |-> do_out_r)
    else $error("result for a transaction still filling");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid)
    else $error("loaded result not shown");
`endif

endmodule

`default_nettype wire

// ===== sv/sobel_edge_nms_stream_unit.sv =====
// latency: a result leaves 2*width+2 pixel positions after its pixel
// pacing: the back takes one transaction at a time; one that makes a magnitude runs the
//   nine-read walk and nine-step square root, and one that emits a result then suppresses
// reset: rst_n synchronous active low; counters, queue and control clear, config regs
//   return to width 481, height 321, threshold 0; line buffers are not cleared
// ----------------------------------------------------------------------------
// sobel_edge_nms_stream_unit
// streaming bayer sobel edge detector with non-maximum suppression
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_nms_stream_unit #(
  parameter int MAX_WIDTH  = sen_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sen_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pixel input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire sen_pkg::pixel_in_t              in_data,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output sen_pkg::pixel_out_t                  out_data,
  // config writes
  input  wire logic                            cfg_we,
  input  wire logic [sen_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sen_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sen_pkg::*;

  // config registers; width and height are latched into the frame at its first pixel
  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic [MAG_W-1:0]      thresh_r;

  // front to queue
  logic      push, q_full;
  fe_entry_t push_entry;
  // queue to back
  logic      pop, q_valid;
  fe_entry_t q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      thresh_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_THRESH: thresh_r <= cfg_data[MAG_W-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // front: counts position, drops early drains, picks bayer sample
  sen_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // queue lets the front keep taking transactions while the back works
  sen_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (push_entry),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .dout      (q_entry)
  );

  // back: gradients, magnitude, suppression, registered result
  sen_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .ent_valid     (q_valid),
    .ent           (q_entry),
    .ent_pop       (pop),
    .mag_threshold (thresh_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_sobel_edge_nms_stream_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sobel_edge_nms_stream_unit
// Self-checking bench for the bayer sobel edge / nms stream unit. Whole frames
// of random and patterned pixels are sent, with early drain and flush
// transactions mixed in. An in-bench predictor follows every accepted pixel
// transaction and queues the result it should cause. The monitor compares
// each result transaction, field by field, against the oldest queued one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sobel_edge_nms_stream_unit;
  import sen_pkg::*;

  localparam int RING = 2 * MAX_WIDTH_DEF + 4;
  localparam int TAN_LO_Q16 = 27146;
  localparam int TAN_HI_Q16 = 295614;

  typedef enum int {PAT_RANDOM, PAT_VSTEP, PAT_HSTEP, PAT_DIAG, PAT_FLAT, PAT_CHECKER} pattern_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  pixel_in_t  in_data;
  logic       out_valid;
  logic       out_stall;
  pixel_out_t out_data;
  logic       cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sobel_edge_nms_stream_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // pixel transactions waiting for the driver, results the predictor expects
  pixel_in_t  pending_pixels[$];
  pixel_out_t expected_pixels[$];
  int         error_count = 0;
  bit         idle_enable = 0;   // random idling on both channels
  bit         in_took = 0;       // input transaction accepted at last rising edge

  // shadow of the config registers and the predictor's own frame state
  int shadow_width  = WIDTH_RST;
  int shadow_height = HEIGHT_RST;
  int shadow_thresh = 0;
  int frame_w = 3, frame_h = 3;
  int col_pos = 0, row_pos = 0;
  logic [7:0] gray_ring[RING];
  int mag_ring[RING];
  int gx_ring[RING];
  int gy_ring[RING];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_size(int v);
    if (v < 3) return 3;
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  // mirror about the border without repeating the edge sample
  function automatic int gray_at(int r, int c);
    if (r < 0) r = 1;
    else if (r >= frame_h) r = frame_h - 2;
    if (c < 0) c = 1;
    else if (c >= frame_w) c = frame_w - 2;
    return gray_ring[(r * frame_w + c) % RING];
  endfunction

  function automatic int mag_at(int r, int c);
    return mag_ring[(r * frame_w + c) % RING];
  endfunction

  function automatic void gradient_at(int m);
    int r, c, gx, gy, mag, sq;
    r = m / frame_w;
    c = m % frame_w;
    gx = gray_at(r-1, c+1) + 2*gray_at(r, c+1) + gray_at(r+1, c+1)
       - gray_at(r-1, c-1) - 2*gray_at(r, c-1) - gray_at(r+1, c-1);
    gy = gray_at(r-1, c-1) + 2*gray_at(r-1, c) + gray_at(r-1, c+1)
       - gray_at(r+1, c-1) - 2*gray_at(r+1, c) - gray_at(r+1, c+1);
    gx = gx / 4;
    gy = gy / 4;
    sq = gx*gx + gy*gy;
    mag = 0;
    while ((mag+1)*(mag+1) <= sq) mag++;
    if (mag <= shadow_thresh) mag = 0;
    mag_ring[m % RING] = mag;
    gx_ring[m % RING] = gx;
    gy_ring[m % RING] = gy;
  endfunction

  function automatic int suppressed_mag(int p);
    int r, c, m, gx, gy, a, b, n1, n2;
    r = p / frame_w;
    c = p % frame_w;
    m = mag_ring[p % RING];
    gx = gx_ring[p % RING];
    gy = gy_ring[p % RING];
    // frame border and flat spots pass through
    if (r == 0 || c == 0 || r == frame_h-1 || c == frame_w-1) return m;
    if (gx == 0 && gy == 0) return m;
    a = (gx < 0) ? -gx : gx;
    b = (gy < 0) ? -gy : gy;
    if (gx != 0 && b*65536 < TAN_LO_Q16*a) begin
      n1 = mag_at(r-1, c); n2 = mag_at(r+1, c);
    end else if (gx != 0 && b*65536 < TAN_HI_Q16*a) begin
      if ((gx > 0) == (gy > 0)) begin
        n1 = mag_at(r-1, c-1); n2 = mag_at(r+1, c+1);
      end else begin
        n1 = mag_at(r-1, c+1); n2 = mag_at(r+1, c-1);
      end
    end else begin
      n1 = mag_at(r, c-1); n2 = mag_at(r, c+1);
    end
    return (m < n1 || m < n2) ? 0 : m;
  endfunction

  // advance the predictor by one accepted transaction
  function automatic void sobel_nms_predict(pixel_in_t px);
    int total, q, lag1, lag2, mag;
    logic [7:0] sample;
    pixel_out_t res;
    bit done;
    done = 0;
    if (row_pos == 0 && col_pos == 0) begin
      frame_w = clamp_size(shadow_width);
      frame_h = clamp_size(shadow_height);
    end
    total = frame_w * frame_h;
    q = row_pos * frame_w + col_pos;
    lag1 = frame_w + 1;
    lag2 = 2*frame_w + 2;
    if (q < total) begin
      if (px.drain) return;  // early drain is ignored
      if (row_pos % 2 == 0) sample = (col_pos % 2) ? px.green : px.red;
      else sample = (col_pos % 2) ? px.blue : px.green;
      gray_ring[q % RING] = sample;
    end
    if (q >= lag1 && q - lag1 < total) gradient_at(q - lag1);
    if (q >= lag2) begin
      mag = suppressed_mag(q - lag2);
      done = (q - lag2 == total - 1);
      res.edge_pixel = (mag != 0) ? EDGE_ON : EDGE_OFF;
      res.magnitude = mag[MAG_W-1:0];
      res.last = done;
      expected_pixels.push_back(res);
    end
    if (done) begin
      row_pos = 0;
      col_pos = 0;
    end else begin
      col_pos++;
      if (col_pos >= frame_w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endfunction

  // monitor: config shadow, input prediction and result checking
  always @(posedge clk) begin
    pixel_out_t exp_px;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  shadow_width  = cfg_data;
          REG_HEIGHT: shadow_height = cfg_data;
          REG_THRESH: shadow_thresh = cfg_data[MAG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result transaction %p", $time, out_data);
          error_count++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_data.edge_pixel !== exp_px.edge_pixel) begin
            $display("%0t: edge_pixel expected %0d actual %0d", $time,
                     exp_px.edge_pixel, out_data.edge_pixel);
            error_count++;
          end
          if (out_data.magnitude !== exp_px.magnitude) begin
            $display("%0t: magnitude expected %0d actual %0d", $time,
                     exp_px.magnitude, out_data.magnitude);
            error_count++;
          end
          if (out_data.last !== exp_px.last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_px.last, out_data.last);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) sobel_nms_predict(in_data);
    end
  end

  // driver: pixel transactions from the pending queue, random idle bursts
  int in_gap = 0;
  int out_gap = 0;
  always @(negedge clk) begin
    bit drive_next;
    drive_next = 0;
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_pixels.size() != 0) begin
        if (idle_enable && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 14) - 1;
        else drive_next = 1;
      end
      if (drive_next) in_data <= pending_pixels.pop_front();
      in_valid <= drive_next;
    end
    // receiver stalls
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1;
    end else if (idle_enable && $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(1, 14) - 1;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // block is idle once nothing is queued or expected, plus a latency margin
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [7:0] pattern_value(pattern_t pat, int r, int c, int w, int h);
    case (pat)
      PAT_VSTEP:   return (c < w/2) ? 8'd0 : 8'd255;
      PAT_HSTEP:   return (r < h/2) ? 8'd255 : 8'd0;
      PAT_DIAG:    return (r + c < (w + h) / 2) ? 8'd20 : 8'd230;
      PAT_FLAT:    return 8'd128;
      PAT_CHECKER: return ((r + c) % 2) ? 8'd255 : 8'd0;
      default:     return 8'($urandom);
    endcase
  endfunction

  // one whole frame plus its flush transactions; returns non-ignored count
  function automatic int queue_frame(int w, int h, pattern_t pat, bit early_drains);
    pixel_in_t px;
    logic [7:0] v;
    int n;
    w = clamp_size(w);
    h = clamp_size(h);
    n = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (early_drains && $urandom_range(0, 15) == 0) begin
          px = pixel_in_t'($urandom);
          px.drain = 1;
          pending_pixels.push_back(px);
        end
        v = pattern_value(pat, r, c, w, h);
        px.red = v; px.green = v; px.blue = v;
        if (pat != PAT_RANDOM && $urandom_range(0, 3) == 0) begin
          px.red = v ^ 8'($urandom_range(0, 7));
          px.green = v ^ 8'($urandom_range(0, 7));
          px.blue = v ^ 8'($urandom_range(0, 7));
        end else if (pat == PAT_RANDOM) begin
          px.red = $urandom; px.green = $urandom; px.blue = $urandom;
        end
        px.drain = 0;
        pending_pixels.push_back(px);
        n++;
      end
    end
    // flush: pixel bytes and drain flag do not matter any more
    for (int i = 0; i < 2*w + 2; i++) begin
      px = pixel_in_t'($urandom);
      pending_pixels.push_back(px);
      n++;
    end
    return n;
  endfunction

  task automatic set_frame(int w, int h, int thresh);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_THRESH, thresh);
  endtask

  initial begin
    pixel_in_t px;
    int sent, w, h, th, dummy;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: sizes below the minimum clamp to 3x3, extreme bytes, an early drain
    set_frame(0, 2, 0);
    px = '0;
    pending_pixels.push_back(px);
    px = '1;
    pending_pixels.push_back(px);                 // early drain, ignored
    px.drain = 0;
    for (int i = 1; i < 9; i++) begin
      pending_pixels.push_back(px);
      px = (i % 2) ? pixel_in_t'('0) : pixel_in_t'({8'hff, 8'h00, 8'haa, 1'b0});
    end
    for (int i = 0; i < 8; i++) begin
      px = (i % 2) ? pixel_in_t'('1) : pixel_in_t'('0);  // flush with either drain value
      pending_pixels.push_back(px);
    end
    wait_idle();

    // highest threshold leaves no edges; above-range threshold register bits
    set_frame(1, 5, 361);
    dummy = queue_frame(3, 5, PAT_CHECKER, 0);
    wait_idle();
    set_frame(6, 6, 511);
    dummy = queue_frame(6, 6, PAT_VSTEP, 0);
    wait_idle();

    // random small frames with random idling
    sent = 0;
    while (sent < 650) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 14);
      h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8);
      case ($urandom_range(0, 3))
        0: th = 0;
        1: th = $urandom_range(0, 40);
        2: th = $urandom_range(0, 511);
        default: th = $urandom_range(0, 120);
      endcase
      set_frame(w, h, th);
      idle_enable = $urandom_range(0, 3) != 0;
      sent += queue_frame(w, h, pattern_t'($urandom_range(0, 5)), $urandom_range(0, 1));
      wait_idle();
    end

    // a wider frame
    idle_enable = 1;
    set_frame(40, 4, 10);
    dummy = queue_frame(40, 4, PAT_DIAG, 0);
    wait_idle();

    // closing frames with no idling at all
    idle_enable = 0;
    repeat (3) begin
      set_frame($urandom_range(3, 12), $urandom_range(3, 6), $urandom_range(0, 30));
      dummy = queue_frame(shadow_width, shadow_height, PAT_RANDOM, 1);
      wait_idle();
    end

    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/sen_pkg.sv
sv/sen_fifo.sv
sv/sen_front.sv
sv/sen_back.sv
sv/sobel_edge_nms_stream_unit.sv
tb/tb_sobel_edge_nms_stream_unit.sv
